[src/tsrsp_pkg.sv]
// Shared types, register codes and reset values for the two-side ramp speed profile.
// No dependencies; every other file imports this package.
package tsrsp_pkg;

    // Default widths for the top-level parameters
    localparam int POS_BITS_DEF   = 24;
    localparam int SPEED_BITS_DEF = 11;

    // Fixed field widths of the configuration registers
    localparam int CRUISE_W = 10;
    localparam int PCT_W    = 7;
    localparam int WIN_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Full scale of the percent settings
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [PCT_W-1:0] PCT_MIN  = 7'd1;
    localparam logic [PCT_W-1:0] PCT_MAX  = 7'd99;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_PCT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_PCT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DONE_WINDOW  = 3'd6;

    // Register reset values
    localparam logic [CRUISE_W-1:0] RST_CRUISE_SPEED = 10'd150;
    localparam logic [PCT_W-1:0]    RST_ACCEL_PCT    = 7'd10;
    localparam logic [PCT_W-1:0]    RST_DECEL_PCT    = 7'd80;
    localparam logic [CRUISE_W-1:0] RST_MIN_SPEED    = 10'd20;
    localparam logic [WIN_W-1:0]    RST_DONE_WINDOW  = 16'd100;

    // Ramp segment selected for one side
    localparam logic [1:0] MODE_CRUISE = 2'd0;
    localparam logic [1:0] MODE_ACCEL  = 2'd1;
    localparam logic [1:0] MODE_DECEL  = 2'd2;

    // Lane status toward the top level and the merge stage
    typedef struct packed {
        logic idle;
        logic done;
        logic near;
    } lane_stat_t;

    // Limit a percent setting to 1..99
    function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] v);
        logic [PCT_W-1:0] r;
        r = v;
        if (v < PCT_MIN) begin
            r = PCT_MIN;
        end else if (v > PCT_MAX) begin
            r = PCT_MAX;
        end
        return r;
    endfunction

endpackage

[src/tsrsp_lane.sv]
// One side of the speed profile: ramp segment select, scaled products and a
// restoring divider that yields one quotient bit per cycle. Uses tsrsp_pkg.
module tsrsp_lane
    import tsrsp_pkg::*;
#(
    parameter int POS_BITS   = POS_BITS_DEF,
    parameter int SPEED_BITS = SPEED_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start_i,
    input  logic signed [POS_BITS-1:0]   pos_i,
    input  logic signed [POS_BITS-1:0]   target_i,
    input  logic [CRUISE_W-1:0]          cruise_i,
    input  logic [PCT_W-1:0]             accel_i,
    input  logic [PCT_W-1:0]             decel_i,
    input  logic [CRUISE_W-1:0]          min_i,
    input  logic [WIN_W-1:0]             window_i,
    input  logic                         ack_i,
    output lane_stat_t                   stat_o,
    output logic signed [SPEED_BITS-1:0] speed_o
);

    // Quotient bits: enough to tell any command above both the floor and the limit
    localparam int QB     = ((SPEED_BITS - 1) > CRUISE_W ? (SPEED_BITS - 1) : CRUISE_W) + 1;
    localparam int PW     = POS_BITS;
    localparam int C100_W = CRUISE_W + 7;
    localparam int NUM_W  = C100_W + PW;
    localparam int DEN_W  = PW + PCT_W;
    localparam int CW     = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;
    localparam int CNT_W  = $clog2(QB);
    localparam int AW     = (PW + 1 > WIN_W) ? PW + 1 : WIN_W;
    localparam logic [QB-1:0] SMAX = QB'((1 << (SPEED_BITS - 1)) - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OVF  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_HOLD = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic signed [PW-1:0]        p_reg;
    logic                        tneg_reg, tz_reg, near_reg, fneg_reg;
    logic [PW-1:0]               tn_reg;
    logic signed [PW:0]          pn_reg;
    logic [1:0]                  mode_reg;
    logic                        opneg_reg;
    logic [PW-1:0]               opmag_reg;
    logic [PCT_W-1:0]            fac_reg;
    logic [C100_W-1:0]           c100_reg;
    logic [NUM_W-1:0]            num_reg;
    logic [DEN_W-1:0]            den_reg;
    logic                        ovf_reg;
    logic [CW-1:0]               rem_reg, dsh_reg;
    logic [QB-1:0]               quot_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic signed [SPEED_BITS-1:0] speed_reg;

    // Sign, magnitudes and arrival test of the captured word
    logic signed [PW:0] te, pe, tmag, pnw, dd, dabs;
    logic               near_w;
    always_comb begin
        te     = {target_i[PW-1], target_i};
        pe     = {p_reg[PW-1], p_reg};
        tmag   = target_i[PW-1] ? -te : te;
        pnw    = target_i[PW-1] ? -pe : pe;
        dd     = te - pe;
        dabs   = dd[PW] ? -dd : dd;
        near_w = (AW'(unsigned'(dabs[PW-1:0])) < AW'(window_i));
    end

    // Segment compares and ramp operands
    logic [PCT_W-1:0]         acc_c, dec_c;
    logic signed [PW+8:0]     pn_ext, lhs;
    logic [PW+6:0]            dec_t, acc_t;
    logic                     dec_hit, acc_hit;
    logic signed [PW+1:0]     opw, opabs;
    logic [1:0]               mode_w;
    logic [PCT_W-1:0]         fac_w;
    logic [C100_W-1:0]        cr_ext, c100_w;
    always_comb begin
        acc_c   = clamp_pct(accel_i);
        dec_c   = clamp_pct(decel_i);
        pn_ext  = {{8{pn_reg[PW]}}, pn_reg};
        lhs     = (pn_ext <<< 6) + (pn_ext <<< 5) + (pn_ext <<< 2);
        dec_t   = (PW+7)'(tn_reg) * (PW+7)'(dec_c);
        acc_t   = (PW+7)'(tn_reg) * (PW+7)'(acc_c);
        dec_hit = lhs > $signed({2'b00, dec_t});
        acc_hit = lhs < $signed({2'b00, acc_t});
        if (dec_hit) begin
            mode_w = MODE_DECEL;
            fac_w  = PCT_FULL - dec_c;
            opw    = $signed({2'b00, tn_reg}) - $signed({pn_reg[PW], pn_reg});
        end else begin
            mode_w = acc_hit ? MODE_ACCEL : MODE_CRUISE;
            fac_w  = acc_c;
            opw    = $signed({pn_reg[PW], pn_reg});
        end
        opabs  = opw[PW+1] ? -opw : opw;
        cr_ext = C100_W'(cruise_i);
        c100_w = (cr_ext << 6) + (cr_ext << 5) + (cr_ext << 2);
    end

    // Divider step
    logic          ge;
    always_comb begin
        ge = rem_reg >= dsh_reg;
    end

    // Final sign, floor and limit
    logic [QB-1:0]  qmag, fm, mag, smag;
    logic           qneg, rneg;
    always_comb begin
        fm   = QB'(min_i);
        qmag = ovf_reg ? {QB{1'b1}} : quot_reg;
        qneg = opneg_reg ^ tneg_reg;
        if (mode_reg == MODE_CRUISE) begin
            qmag = QB'(cruise_i);
            qneg = tneg_reg;
        end
        if (tz_reg || (fm > qmag)) begin
            mag  = fm;
            rneg = fneg_reg;
        end else begin
            mag  = qmag;
            rneg = qneg;
        end
        smag = (mag > SMAX) ? SMAX : mag;
    end

    // Sequence one word through the lane
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start_i) state_next = S_PREP;
            S_PREP:  state_next = S_CMP;
            S_CMP:   state_next = S_MUL;
            S_MUL:   state_next = S_OVF;
            S_OVF:   state_next = S_DIV;
            S_DIV:   if (cnt_reg == '0) state_next = S_FIN;
            S_FIN:   state_next = S_HOLD;
            S_HOLD:  if (ack_i) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (start_i) p_reg <= pos_i;
            end
            S_PREP: begin
                tneg_reg <= target_i[PW-1];
                tz_reg   <= (target_i == '0);
                tn_reg   <= tmag[PW-1:0];
                pn_reg   <= pnw;
                near_reg <= near_w;
                fneg_reg <= (p_reg >= target_i);
            end
            S_CMP: begin
                mode_reg  <= mode_w;
                fac_reg   <= fac_w;
                opneg_reg <= opw[PW+1];
                opmag_reg <= opabs[PW-1:0];
                c100_reg  <= c100_w;
            end
            S_MUL: begin
                num_reg <= NUM_W'(c100_reg) * NUM_W'(opmag_reg);
                den_reg <= DEN_W'(tn_reg) * DEN_W'(fac_reg);
            end
            S_OVF: begin
                ovf_reg  <= CW'(num_reg) >= (CW'(den_reg) << QB);
                rem_reg  <= CW'(num_reg);
                dsh_reg  <= CW'(den_reg) << (QB - 1);
                cnt_reg  <= CNT_W'(QB - 1);
                quot_reg <= '0;
            end
            S_DIV: begin
                if (ge) rem_reg <= rem_reg - dsh_reg;
                quot_reg <= {quot_reg[QB-2:0], ge};
                dsh_reg  <= dsh_reg >> 1;
                cnt_reg  <= cnt_reg - CNT_W'(1);
            end
            S_FIN: begin
                speed_reg <= rneg ? -$signed(smag[SPEED_BITS-1:0])
                                  : $signed(smag[SPEED_BITS-1:0]);
            end
            S_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    assign stat_o.idle = (state_reg == S_IDLE);
    assign stat_o.done = (state_reg == S_HOLD);
    assign stat_o.near = near_reg;
    assign speed_o     = speed_reg;

    // Remainder stays below twice the shifted divisor in a bounded division
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && !ovf_reg && !tz_reg) |-> ({1'b0, rem_reg} < {dsh_reg, 1'b0}))
        else $error("lane divider remainder out of range");

endmodule

[src/tsrsp_merge.sv]
// Merge stage: joins both lane results with the arrival flag into the output register.
// Uses tsrsp_pkg for the lane status struct.
module tsrsp_merge
    import tsrsp_pkg::*;
#(
    parameter int SPEED_BITS = SPEED_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lane_stat_t                   stat_l_i,
    input  lane_stat_t                   stat_r_i,
    input  logic signed [SPEED_BITS-1:0] speed_l_i,
    input  logic signed [SPEED_BITS-1:0] speed_r_i,
    output logic                         ack_o,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [SPEED_BITS-1:0] m_speed_left,
    output logic signed [SPEED_BITS-1:0] m_speed_right,
    output logic                         m_arrived
);

    logic                         m_valid_reg;
    logic signed [SPEED_BITS-1:0] spd_l_reg, spd_r_reg;
    logic                         arrived_reg;
    logic                         take;

    // Take both lanes when the output register is free or being drained
    assign take  = stat_l_i.done && stat_r_i.done && (!m_valid_reg || m_ready);
    assign ack_o = take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Load the result word
    always_ff @(posedge aclk) begin
        if (take) begin
            spd_l_reg   <= speed_l_i;
            spd_r_reg   <= speed_r_i;
            arrived_reg <= stat_l_i.near && stat_r_i.near;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_speed_left  = spd_l_reg;
    assign m_speed_right = spd_r_reg;
    assign m_arrived     = arrived_reg;

    // A taken pair always shows up on the output next cycle
    a_take_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> m_valid_reg)
        else $error("merged word lost");

endmodule

[src/two_side_ramp_speed_profile_unit.sv]
// Top level of the two-side ramp speed profile: configuration registers, input
// buffer, two lanes and the merge stage. Uses tsrsp_pkg, tsrsp_lane, tsrsp_merge.
//
//   channel | ports                                  | direction | word
//   --------+----------------------------------------+-----------+------------------------
//   input   | s_valid s_ready s_pos_left s_pos_right  | in        | encoder positions
//   result  | m_valid m_ready m_speed_left/right ... | out       | speeds and arrived flag
//   config  | cfg_valid cfg_ready cfg_index cfg_data  | in        | register write
//
// Each word passes the lane states PREP, CMP, MUL, OVF, DIV and FIN; the restoring
// divider in each lane yields one quotient bit per cycle, QB = max(SPEED_BITS-1, 10) + 1
// bits in all. Both lanes run in lockstep on the same word.
// A one-word input buffer takes the next word while the lanes work; s_ready drops only
// while it is full. A finished word sits in the output register while the lanes continue.
// Synchronous active-low reset restores the register defaults; no clearing pass.
module two_side_ramp_speed_profile_unit
    import tsrsp_pkg::*;
#(
    parameter int POS_BITS   = POS_BITS_DEF,
    parameter int SPEED_BITS = SPEED_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [POS_BITS-1:0]   s_pos_left,
    input  logic signed [POS_BITS-1:0]   s_pos_right,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [SPEED_BITS-1:0] m_speed_left,
    output logic signed [SPEED_BITS-1:0] m_speed_right,
    output logic                         m_arrived,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [((POS_BITS > WIN_W) ? POS_BITS : WIN_W)-1:0] cfg_data
);

    logic signed [POS_BITS-1:0] target_l_reg, target_r_reg;
    logic [CRUISE_W-1:0]        cruise_reg, min_reg;
    logic [PCT_W-1:0]           accel_reg, decel_reg;
    logic [WIN_W-1:0]           window_reg;

    logic                       in_full_reg;
    logic signed [POS_BITS-1:0] pos_l_reg, pos_r_reg;

    lane_stat_t                   stat_l, stat_r;
    logic signed [SPEED_BITS-1:0] speed_l, speed_r;
    logic                         start, ack;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_l_reg <= '0;
            target_r_reg <= '0;
            cruise_reg   <= RST_CRUISE_SPEED;
            accel_reg    <= RST_ACCEL_PCT;
            decel_reg    <= RST_DECEL_PCT;
            min_reg      <= RST_MIN_SPEED;
            window_reg   <= RST_DONE_WINDOW;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TARGET_LEFT:  target_l_reg <= cfg_data[POS_BITS-1:0];
                REG_TARGET_RIGHT: target_r_reg <= cfg_data[POS_BITS-1:0];
                REG_CRUISE_SPEED: cruise_reg   <= cfg_data[CRUISE_W-1:0];
                REG_ACCEL_PCT:    accel_reg    <= cfg_data[PCT_W-1:0];
                REG_DECEL_PCT:    decel_reg    <= cfg_data[PCT_W-1:0];
                REG_MIN_SPEED:    min_reg      <= cfg_data[CRUISE_W-1:0];
                REG_DONE_WINDOW:  window_reg   <= cfg_data[WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input buffer: hold one word until both lanes are free
    assign s_ready = !in_full_reg;
    assign start   = in_full_reg && stat_l.idle && stat_r.idle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_full_reg <= 1'b1;
        end else if (start) begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pos_l_reg <= s_pos_left;
            pos_r_reg <= s_pos_right;
        end
    end

    tsrsp_lane #(
        .POS_BITS   (POS_BITS),
        .SPEED_BITS (SPEED_BITS)
    ) u_lane_left (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start_i  (start),
        .pos_i    (pos_l_reg),
        .target_i (target_l_reg),
        .cruise_i (cruise_reg),
        .accel_i  (accel_reg),
        .decel_i  (decel_reg),
        .min_i    (min_reg),
        .window_i (window_reg),
        .ack_i    (ack),
        .stat_o   (stat_l),
        .speed_o  (speed_l)
    );

    tsrsp_lane #(
        .POS_BITS   (POS_BITS),
        .SPEED_BITS (SPEED_BITS)
    ) u_lane_right (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start_i  (start),
        .pos_i    (pos_r_reg),
        .target_i (target_r_reg),
        .cruise_i (cruise_reg),
        .accel_i  (accel_reg),
        .decel_i  (decel_reg),
        .min_i    (min_reg),
        .window_i (window_reg),
        .ack_i    (ack),
        .stat_o   (stat_r),
        .speed_o  (speed_r)
    );

    tsrsp_merge #(
        .SPEED_BITS (SPEED_BITS)
    ) u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .stat_l_i      (stat_l),
        .stat_r_i      (stat_r),
        .speed_l_i     (speed_l),
        .speed_r_i     (speed_r),
        .ack_o         (ack),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_speed_left  (m_speed_left),
        .m_speed_right (m_speed_right),
        .m_arrived     (m_arrived)
    );

    // Lanes start together and take the same number of cycles
    a_lanes_done: assert property (@(posedge aclk) disable iff (!aresetn)
        stat_l.done == stat_r.done)
        else $error("lanes finished out of step");

    a_lanes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        stat_l.idle == stat_r.idle)
        else $error("lanes idle out of step");

endmodule
